### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/bdqs_pkg.sv
`default_nettype none

package bdqs_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // What every cell does with its value each cycle.
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_BACK,
    SH_FRONT,
    SH_LOAD
  } shift_t;

  typedef struct packed {
    shift_t shift;
    logic   search;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand_value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped_value;
    logic [3:0]         match_position;
    logic [4:0]         entry_count;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/bdqs_cell.sv
`default_nettype none

module bdqs_cell #(
  parameter int VALUE_WIDTH = bdqs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bdqs_pkg::cell_ctl_t    ctl,
  input  wire logic                   sel,
  input  wire logic                   valid,
  input  wire logic [VALUE_WIDTH-1:0] operand,
  input  wire logic [VALUE_WIDTH-1:0] val_prev,
  input  wire logic [VALUE_WIDTH-1:0] val_next,
  output logic      [VALUE_WIDTH-1:0] val,
  output logic                        match
);

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   match_r, match_nxt;

  always_comb begin
    case (ctl.shift)
      bdqs_pkg::SH_BACK:  val_nxt = val_prev;
      bdqs_pkg::SH_FRONT: val_nxt = val_next;
      bdqs_pkg::SH_LOAD:  val_nxt = sel ? operand : val_r;
      default:            val_nxt = val_r;
    endcase
    match_nxt = ctl.search ? (valid && (val_r == operand)) : match_r;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

`default_nettype wire

### rtl/core/bdqs_prio.sv
`default_nettype none

module bdqs_prio #(
  parameter int N  = bdqs_pkg::CAPACITY_DEF,
  parameter int IW = $clog2(N)
) (
  input  wire logic [N-1:0]  match,
  output logic               found,
  output logic [IW-1:0]      idx
);

  // Lowest set bit wins: scan from the back so the front overrides.
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        idx = IW'(i);
      end
    end
    found = |match;
  end

endmodule

`default_nettype wire

### rtl/core/bounded_deque_with_search.sv
`default_nettype none
`include "assert_macros.svh"

// Bounded double-ended queue of signed values with a search from the front.
// Input: drive in_item and raise start; the item is taken at a clock edge
// where start is high and busy is low. Commands: push front, push back,
// pop front, pop back, search; unused codes do nothing.
// Output: out_valid is high for one cycle with out_item, which carries the
// status, the popped value, the match position and the entry count.
// The item passes through the execute state; its result is then shown in the result state.
// Busy is high for the one execute cycle in which the row of cells shifts
// or compares, and the next item may be taken in the same cycle that a
// result is shown.
// The first-match index is encoded from the cells' registered compare bits
// during the result cycle.
// Reset: the queue is emptied and any item in flight is dropped.
// The receiver cannot stall; each result is shown exactly once.
module bounded_deque_with_search #(
  parameter int CAPACITY    = bdqs_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bdqs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire bdqs_pkg::in_t  in_item,
  output logic                out_valid,
  output bdqs_pkg::out_t      out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  bdqs_pkg::state_t  state_r, state_nxt;
  logic [2:0]             cmd_r;
  logic [VALUE_WIDTH-1:0] opnd_r;
  logic [CW-1:0]          count_r, count_nxt;
  bdqs_pkg::status_t      status_r, status_nxt;
  logic [VALUE_WIDTH-1:0] pop_r, pop_nxt;
  logic                   srch_r, srch_nxt;

  bdqs_pkg::cell_ctl_t    ctl;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  logic [VALUE_WIDTH-1:0] pop_tail;
  logic                   accept, full, empty, found;
  logic [IW-1:0]          match_idx;

  assign accept = start && !busy;
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);

  // State machine: next state
  always_comb begin
    unique case (state_r)
      bdqs_pkg::ST_IDLE: state_nxt = start ? bdqs_pkg::ST_EXEC : bdqs_pkg::ST_IDLE;
      bdqs_pkg::ST_EXEC: state_nxt = bdqs_pkg::ST_RESP;
      bdqs_pkg::ST_RESP: state_nxt = start ? bdqs_pkg::ST_EXEC : bdqs_pkg::ST_IDLE;
      default:           state_nxt = bdqs_pkg::ST_IDLE;
    endcase
  end

  // State machine: outputs
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bdqs_pkg::ST_EXEC: busy      = 1'b1;
      bdqs_pkg::ST_RESP: out_valid = 1'b1;
      default: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdqs_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_item.cmd;
      opnd_r <= VALUE_WIDTH'(in_item.operand_value);
    end
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    srch_r   <= srch_nxt;
  end

  // Value at the back, picked out of the row by the current count.
  always_comb begin
    pop_tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pop_tail = pop_tail |
        (cell_val[i] & {VALUE_WIDTH{(CW'(i + 1) == count_r)}});
    end
  end

  // Execute-cycle decode
  always_comb begin
    ctl.shift  = bdqs_pkg::SH_HOLD;
    ctl.search = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    pop_nxt    = pop_r;
    srch_nxt   = srch_r;
    if (state_r == bdqs_pkg::ST_EXEC) begin
      status_nxt = bdqs_pkg::STAT_DONE;
      pop_nxt    = '0;
      srch_nxt   = 1'b0;
      unique case (cmd_r) inside
        bdqs_pkg::CMD_PUSH_FRONT, bdqs_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = bdqs_pkg::STAT_FULL;
          end else begin
            ctl.shift = (cmd_r == bdqs_pkg::CMD_PUSH_FRONT) ?
                        bdqs_pkg::SH_BACK : bdqs_pkg::SH_LOAD;
            count_nxt = count_r + CW'(1);
          end
        end
        bdqs_pkg::CMD_POP_FRONT, bdqs_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_nxt = bdqs_pkg::STAT_EMPTY;
          end else begin
            if (cmd_r == bdqs_pkg::CMD_POP_FRONT) begin
              ctl.shift = bdqs_pkg::SH_FRONT;
              pop_nxt   = cell_val[0];
            end else begin
              pop_nxt   = pop_tail;
            end
            count_nxt = count_r - CW'(1);
          end
        end
        bdqs_pkg::CMD_SEARCH: begin
          ctl.search = 1'b1;
          srch_nxt   = 1'b1;
        end
        default: begin
          status_nxt = bdqs_pkg::STAT_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_v, next_v;
    if (i == 0) begin : g_first
      assign prev_v = opnd_r;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    bdqs_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sel      (CW'(i) == count_r),
      .valid    (CW'(i) < count_r),
      .operand  (opnd_r),
      .val_prev (prev_v),
      .val_next (next_v),
      .val      (cell_val[i]),
      .match    (cell_match[i])
    );
  end

  bdqs_prio #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_prio (
    .match (cell_match),
    .found (found),
    .idx   (match_idx)
  );

  always_comb begin
    out_item.status         = status_r;
    out_item.popped_value   = 32'(pop_r);
    out_item.match_position = '0;
    out_item.entry_count    = 5'(count_r);
    if (srch_r) begin
      out_item.status = found ? bdqs_pkg::STAT_DONE : bdqs_pkg::STAT_NOT_FOUND;
      if (found) begin
        out_item.match_position = 4'(match_idx);
      end
    end
  end

  `ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `ASSERT_NXT(a_accept_busy, accept, busy)
  `ASSERT_NXT(a_exec_result, busy, out_valid && !busy)
  `ASSERT_IMP(a_full_count, out_valid && !srch_r && (status_r == bdqs_pkg::STAT_FULL), count_r == CW'(CAPACITY))

endmodule

`default_nettype wire
